@@ hw/rtl/rhf_pkg.sv @@
`timescale 1ns / 1ps

package rhf_pkg;

   localparam logic [63:0] DJB2_START = 64'd5381;

   localparam int CRITICAL_DEPTH_DEF = 16;
   localparam int TRAIL_DEPTH_DEF    = 32;

   // item kinds
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // message type codes
   localparam logic [1:0] MSG_SOS     = 2'd0;
   localparam logic [1:0] MSG_CHECKIN = 2'd1;
   localparam logic [1:0] MSG_TRAIL   = 2'd2;

   // hash operand select
   localparam logic [1:0] FOLD_NONE   = 2'd0;
   localparam logic [1:0] FOLD_BYTE   = 2'd1;
   localparam logic [1:0] FOLD_SUFFIX = 2'd2;
   localparam logic [1:0] FOLD_DIGIT  = 2'd3;

   // decimal conversion by reciprocal multiply
   localparam int          DEC_DIGITS = 10;
   localparam logic [31:0] DEC_RECIP  = 32'hCCCC_CCCD;
   localparam int          DEC_SHIFT  = 35;

   // suffix texts, first character in the top byte
   localparam int SUFFIX_MAX = 14;
   localparam logic [8*SUFFIX_MAX-1:0] TEXT_SOS     = {":SOS:", 72'd0};
   localparam logic [8*SUFFIX_MAX-1:0] TEXT_CHECKIN = {":CheckIn:", 40'd0};
   localparam logic [8*SUFFIX_MAX-1:0] TEXT_TRAIL   = ":TrailMessage:";

   typedef struct packed {
      logic [1:0] fold_sel;
      logic [3:0] suffix_idx;
      logic       load_item;
      logic       dec_pop;
      logic       search_clear;
      logic       search_read;
      logic       commit;
   } rhf_cmd_type;

   typedef struct packed {
      logic suffix_last;
      logic dec_done;
      logic dec_empty;
      logic search_last;
   } rhf_status_type;

   function automatic logic [3:0] suffix_len(input logic [1:0] kind);
      logic [3:0] len;
      case (kind)
         MSG_SOS:     len = 4'd5;
         MSG_CHECKIN: len = 4'd9;
         default:     len = 4'd14;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] suffix_char(input logic [1:0] kind, input logic [3:0] idx);
      logic [8*SUFFIX_MAX-1:0] text;
      logic [7:0]              ch;
      case (kind)
         MSG_SOS:     text = TEXT_SOS;
         MSG_CHECKIN: text = TEXT_CHECKIN;
         default:     text = TEXT_TRAIL;
      endcase
      if (int'(idx) < SUFFIX_MAX) begin
         ch = text[8*(SUFFIX_MAX-1-int'(idx)) +: 8];
      end else begin
         ch = 8'd0;
      end
      return ch;
   endfunction

endpackage

@@ hw/rtl/replay_hash_filter.sv @@
`timescale 1ns / 1ps

// Replay filter keyed by a 64-bit djb2 hash. Each append transfer folds one
// sender byte into the running hash as it is accepted. A finish transfer
// folds ":<type name>:" (5, 9 or 14 characters) while the timestamp is converted
// to decimal alongside (a multiply step and a digit push per digit, 1 to 10
// digits), then folds one digit per cycle, then searches the class ring one
// entry per cycle through its registered memory read port, and finally commits.
// Only one finish transfer is in work at a time; a result waits in an output
// register while append transfers keep being taken. Ring contents after reset are
// tracked by fill counts, so there is no clearing pass after reset. The
// char_sign_extend register is written through csr_wr_en / csr_wr_data.

module replay_hash_filter #(
   parameter int CRITICAL_DEPTH = rhf_pkg::CRITICAL_DEPTH_DEF,
   parameter int TRAIL_DEPTH    = rhf_pkg::TRAIL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // char_sign_extend
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,     // sender_byte[7:0], msg_type[9:8], msg_time[41:10]
   input  logic        req_tuser,     // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,     // key_hash[63:0]
   output logic        rsp_tuser      // is_replay
);
   import rhf_pkg::*;

   rhf_cmd_type    cmd;
   rhf_status_type status;

   rhf_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   rhf_datapath #(
      .CRITICAL_DEPTH (CRITICAL_DEPTH),
      .TRAIL_DEPTH    (TRAIL_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_sender_byte (req_tdata[7:0]),
      .req_msg_type    (req_tdata[9:8]),
      .req_msg_time    (req_tdata[41:10]),
      .cmd             (cmd),
      .status          (status),
      .rsp_is_replay   (rsp_tuser),
      .rsp_key_hash    (rsp_tdata)
   );

endmodule

@@ hw/rtl/rhf_decimal.sv @@
`timescale 1ns / 1ps

module rhf_decimal (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   input  logic        pop,
   output logic        done,
   output logic        empty,
   output logic [3:0]  digit
);
   import rhf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic [31:0]          v_ff, v_in;
   logic [63:0]          prod_ff, prod_in;
   logic [3:0]           stk_ff [DEC_DIGITS];
   logic [3:0]           stk_in [DEC_DIGITS];
   logic [3:0]           n_ff, n_in;
   logic [63-DEC_SHIFT:0] quot;
   logic [31:0]          quot10;
   logic [31:0]          rem;

   always_comb begin
      quot   = prod_ff[63:DEC_SHIFT];
      quot10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
      rem    = v_ff - quot10;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      v_in     = v_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      for (int k = 0; k < DEC_DIGITS; k++) begin
         stk_in[k] = stk_ff[k];
      end
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         v_in     = value;
         n_in     = 4'd0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            prod_in  = 64'(v_ff) * 64'(DEC_RECIP);
            phase_in = 1'b1;
         end else begin
            // push least significant digit first
            stk_in[0] = rem[3:0];
            for (int k = 1; k < DEC_DIGITS; k++) begin
               stk_in[k] = stk_ff[k-1];
            end
            v_in     = 32'(quot);
            n_in     = n_ff + 4'd1;
            phase_in = 1'b0;
            if (quot == '0) begin
               busy_in = 1'b0;
            end
         end
      end else if (pop && n_ff != 4'd0) begin
         for (int k = 0; k < DEC_DIGITS - 1; k++) begin
            stk_in[k] = stk_ff[k+1];
         end
         stk_in[DEC_DIGITS-1] = 4'd0;
         n_in = n_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         n_ff     <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      prod_ff <= prod_in;
      for (int k = 0; k < DEC_DIGITS; k++) begin
         stk_ff[k] <= stk_in[k];
      end
   end

   assign done  = !busy_ff && !start;
   assign empty = (n_ff == 4'd0);
   assign digit = stk_ff[0];

endmodule

@@ hw/rtl/rhf_datapath.sv @@
`timescale 1ns / 1ps

module rhf_datapath #(
   parameter int CRITICAL_DEPTH = rhf_pkg::CRITICAL_DEPTH_DEF,
   parameter int TRAIL_DEPTH    = rhf_pkg::TRAIL_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic [7:0]              req_sender_byte,
   input  logic [1:0]              req_msg_type,
   input  logic [31:0]             req_msg_time,
   input  rhf_pkg::rhf_cmd_type    cmd,
   output rhf_pkg::rhf_status_type status,
   output logic                    rsp_is_replay,
   output logic [63:0]             rsp_key_hash
);
   import rhf_pkg::*;

   localparam int CAW = (CRITICAL_DEPTH > 1) ? $clog2(CRITICAL_DEPTH) : 1;
   localparam int TAW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
   localparam int CCW = $clog2(CRITICAL_DEPTH + 1);
   localparam int TCW = $clog2(TRAIL_DEPTH + 1);
   localparam int SW  = (CCW > TCW) ? CCW : TCW;

   logic        sign_ff;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] operand;
   logic [1:0]  type_ff;
   logic        crit_ff;
   logic        crit_sel;

   logic        dec_done, dec_empty;
   logic [3:0]  dec_digit;

   logic [63:0] crit_mem [CRITICAL_DEPTH];
   logic [63:0] trail_mem [TRAIL_DEPTH];
   logic [63:0] crit_rd_ff, trail_rd_ff, rd_data;
   logic [CAW-1:0] crit_ptr_ff;
   logic [TAW-1:0] trail_ptr_ff;
   logic [CCW-1:0] crit_cnt_ff;
   logic [TCW-1:0] trail_cnt_ff;
   logic [SW-1:0]  saddr_ff;
   logic           rd_valid_ff, rd_filled_ff, filled;
   logic           hit_ff, match;

   logic        replay_ff;
   logic [63:0] key_ff;

   rhf_decimal u_decimal (
      .clock (clock),
      .reset (reset),
      .start (cmd.load_item),
      .value (req_msg_time),
      .pop   (cmd.dec_pop),
      .done  (dec_done),
      .empty (dec_empty),
      .digit (dec_digit)
   );

   always_comb begin
      crit_sel = req_msg_type inside {MSG_SOS, MSG_CHECKIN};
      case (cmd.fold_sel)
         FOLD_BYTE:   operand = {{56{sign_ff & req_sender_byte[7]}}, req_sender_byte};
         FOLD_SUFFIX: operand = {56'd0, suffix_char(type_ff, cmd.suffix_idx)};
         FOLD_DIGIT:  operand = {56'd0, 4'h3, dec_digit};
         default:     operand = 64'd0;
      endcase
      if (cmd.commit) begin
         hash_in = DJB2_START;
      end else if (cmd.fold_sel != FOLD_NONE) begin
         hash_in = hash_ff + {hash_ff[58:0], 5'd0} + operand;
      end else begin
         hash_in = hash_ff;
      end
   end

   always_comb begin
      rd_data = crit_ff ? crit_rd_ff : trail_rd_ff;
      filled  = crit_ff ? (saddr_ff < SW'(crit_cnt_ff)) : (saddr_ff < SW'(trail_cnt_ff));
      match   = rd_filled_ff ? (rd_data == hash_ff) : (hash_ff == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff      <= 1'b0;
         hash_ff      <= DJB2_START;
         crit_ptr_ff  <= '0;
         trail_ptr_ff <= '0;
         crit_cnt_ff  <= '0;
         trail_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         saddr_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            sign_ff <= csr_wr_data;
         end
         hash_ff <= hash_in;
         if (cmd.search_clear) begin
            saddr_ff    <= '0;
            hit_ff      <= 1'b0;
            rd_valid_ff <= 1'b0;
         end else begin
            rd_valid_ff <= cmd.search_read;
            if (cmd.search_read) begin
               saddr_ff <= saddr_ff + 1'b1;
            end
            if (rd_valid_ff && match) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.commit && !hit_ff) begin
            if (crit_ff) begin
               crit_ptr_ff <= (crit_ptr_ff == CAW'(CRITICAL_DEPTH - 1)) ? '0
                              : crit_ptr_ff + 1'b1;
               if (crit_cnt_ff != CCW'(CRITICAL_DEPTH)) begin
                  crit_cnt_ff <= crit_cnt_ff + 1'b1;
               end
            end else begin
               trail_ptr_ff <= (trail_ptr_ff == TAW'(TRAIL_DEPTH - 1)) ? '0
                               : trail_ptr_ff + 1'b1;
               if (trail_cnt_ff != TCW'(TRAIL_DEPTH)) begin
                  trail_cnt_ff <= trail_cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         type_ff <= req_msg_type;
         crit_ff <= crit_sel;
      end
      rd_filled_ff <= filled;
      if (cmd.commit) begin
         replay_ff <= hit_ff;
         key_ff    <= hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      crit_rd_ff <= crit_mem[saddr_ff[CAW-1:0]];
      if (cmd.commit && !hit_ff && crit_ff) begin
         crit_mem[crit_ptr_ff] <= hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      trail_rd_ff <= trail_mem[saddr_ff[TAW-1:0]];
      if (cmd.commit && !hit_ff && !crit_ff) begin
         trail_mem[trail_ptr_ff] <= hash_ff;
      end
   end

   always_comb begin
      status.suffix_last = (cmd.suffix_idx == suffix_len(type_ff) - 4'd1);
      status.dec_done    = dec_done;
      status.dec_empty   = dec_empty;
      status.search_last = crit_ff ? (saddr_ff == SW'(CRITICAL_DEPTH - 1))
                                   : (saddr_ff == SW'(TRAIL_DEPTH - 1));
   end

   assign rsp_is_replay = replay_ff;
   assign rsp_key_hash  = key_ff;

endmodule

@@ hw/rtl/rhf_controller.sv @@
`timescale 1ns / 1ps

module rhf_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_cmd,
   output logic                    req_tready,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output rhf_pkg::rhf_cmd_type    cmd,
   input  rhf_pkg::rhf_status_type status
);
   import rhf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SUFFIX = 3'd1;
   localparam logic [2:0] ST_DIGITS = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_SCMP   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   always_comb begin
      accept   = req_tvalid && (state_ff == ST_IDLE);
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd              = '0;
      cmd.fold_sel     = FOLD_NONE;
      cmd.suffix_idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_APPEND) begin
                  cmd.fold_sel = FOLD_BYTE;
               end else begin
                  cmd.load_item = 1'b1;
                  idx_in        = 4'd0;
                  state_in      = ST_SUFFIX;
               end
            end
         end
         ST_SUFFIX: begin
            cmd.fold_sel = FOLD_SUFFIX;
            if (status.suffix_last) begin
               state_in = ST_DIGITS;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_DIGITS: begin
            if (status.dec_done) begin
               if (status.dec_empty) begin
                  cmd.search_clear = 1'b1;
                  state_in         = ST_SEARCH;
               end else begin
                  cmd.fold_sel = FOLD_DIGIT;
                  cmd.dec_pop  = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search_read = 1'b1;
            if (status.search_last) begin
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import rhf_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_ITEMS  = 175;
   localparam logic [1:0] MSG_TYPE3 = 2'd3;

   typedef struct {
      logic        cmd;
      logic [7:0]  sbyte;
      logic [1:0]  mtype;
      logic [31:0] mtime;
   } req_item_type;

   typedef struct {
      logic        replay;
      logic [63:0] hash;
   } key_result_type;

   typedef struct {
      int          len;
      logic [7:0]  b[20];
      logic [1:0]  mtype;
      logic [31:0] mtime;
   } message_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // sender_byte[7:0], msg_type[9:8], msg_time[41:10]
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // key_hash[63:0]
   logic        rsp_tuser;        // is_replay

   // predictor state
   logic [63:0] run_hash = DJB2_START;
   logic [63:0] crit_ring[CRITICAL_DEPTH_DEF];
   logic [63:0] trail_ring[TRAIL_DEPTH_DEF];
   int          crit_ptr = 0;
   int          trail_ptr = 0;
   logic        sign_cfg = 1'b0;

   req_item_type   pending_reqs[$];
   key_result_type expected_keys[$];
   message_type    history[$];

   req_item_type   drv_item;
   key_result_type exp_key;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          accepted_count = 0;
   int          results_seen = 0;
   int          finish_count = 0;
   int          replay_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;

   replay_hash_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (crit_ring[i]) crit_ring[i] = '0;
      foreach (trail_ring[i]) trail_ring[i] = '0;
   end

   function automatic logic [63:0] djb2_step(input logic [63:0] h, input logic [63:0] c);
      return (h << 5) + h + c;
   endfunction

   // ":<type name>:" then the timestamp digits, most significant first
   function automatic logic [63:0] tail_fold(input logic [63:0] h, input logic [1:0] mtype,
                                             input logic [31:0] mtime);
      string       suffix;
      logic [31:0] v;
      logic [7:0]  digs[10];
      int          n;
      case (mtype)
         MSG_SOS:     suffix = ":SOS:";
         MSG_CHECKIN: suffix = ":CheckIn:";
         default:     suffix = ":TrailMessage:";
      endcase
      for (int i = 0; i < suffix.len(); i++) h = djb2_step(h, {56'd0, suffix[i]});
      v = mtime;
      n = 0;
      do begin
         digs[n] = 8'h30 + 8'(v % 10);
         v = v / 10;
         n++;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) h = djb2_step(h, {56'd0, digs[i]});
      return h;
   endfunction

   function automatic void fold_and_lookup(input logic cmd, input logic [7:0] sbyte,
                                           input logic [1:0] mtype, input logic [31:0] mtime);
      logic [63:0]    h;
      logic           hit;
      key_result_type r;
      if (cmd == CMD_APPEND) begin
         run_hash = djb2_step(run_hash, {{56{sign_cfg & sbyte[7]}}, sbyte});
      end else begin
         h = tail_fold(run_hash, mtype, mtime);
         hit = 1'b0;
         if (mtype == MSG_SOS || mtype == MSG_CHECKIN) begin
            foreach (crit_ring[i]) if (crit_ring[i] == h) hit = 1'b1;
            if (!hit) begin
               crit_ring[crit_ptr] = h;
               crit_ptr = (crit_ptr + 1) % CRITICAL_DEPTH_DEF;
            end
         end else begin
            foreach (trail_ring[i]) if (trail_ring[i] == h) hit = 1'b1;
            if (!hit) begin
               trail_ring[trail_ptr] = h;
               trail_ptr = (trail_ptr + 1) % TRAIL_DEPTH_DEF;
            end
         end
         run_hash = DJB2_START;
         r.replay = hit;
         r.hash = h;
         expected_keys.push_back(r);
         finish_count++;
         if (hit) replay_count++;
      end
   endfunction

   // sender bytes 0..32 whose full key hashes to zero
   function automatic message_type build_zero_key(input logic [1:0] mtype,
                                                  input logic [31:0] mtime);
      message_type m;
      logic [63:0] c;
      logic [63:0] mul;
      logic [63:0] inv;
      logic [63:0] base;
      logic [63:0] v;
      c = tail_fold(64'd0, mtype, mtime);
      mul = tail_fold(64'd1, mtype, mtime) - c;
      inv = mul;
      repeat (5) inv = inv * (64'd2 - mul * inv);
      base = DJB2_START;
      repeat (13) base = base * 64'd33;
      v = (64'd0 - c) * inv - base;
      m.len = 13;
      m.mtype = mtype;
      m.mtime = mtime;
      foreach (m.b[i]) m.b[i] = '0;
      for (int i = 12; i >= 0; i--) begin
         m.b[i] = 8'(v % 64'd33);
         v = v / 64'd33;
      end
      return m;
   endfunction

   task automatic push_message(input message_type m);
      req_item_type it;
      for (int i = 0; i < m.len; i++) begin
         it = '{CMD_APPEND, m.b[i], 2'($urandom_range(3)), $urandom()};
         pending_reqs.push_back(it);
      end
      it = '{CMD_FINISH, 8'($urandom_range(255)), m.mtype, m.mtime};
      pending_reqs.push_back(it);
      history.push_back(m);
   endtask

   task automatic drain_filter();
      while (pending_reqs.size() != 0 || req_tvalid || expected_keys.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sign_cfg(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      sign_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic cfg,
                            input int n_items);
      message_type m;
      int          sel;
      int          span;
      int          phase_items;
      write_sign_cfg(cfg);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_items = 0;
      while (phase_items < n_items) begin
         sel = $urandom_range(99);
         span = (history.size() - 1 < 40) ? history.size() - 1 : 40;
         if (sel < 20) begin
            m = history[history.size() - 1 - $urandom_range(span)];
         end else if (sel < 25) begin
            m = build_zero_key(2'($urandom_range(3)), $urandom());
         end else if (sel < 32) begin
            // near miss of an earlier key
            m = history[history.size() - 1 - $urandom_range(span)];
            if (m.len > 0 && $urandom_range(1) == 0) begin
               m.len--;
            end else if (m.len < 20) begin
               m.b[m.len] = 8'($urandom_range(255));
               m.len++;
            end
         end else begin
            m.len = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(19, 7);
            foreach (m.b[i]) m.b[i] = 8'($urandom_range(255));
            m.mtype = 2'($urandom_range(3));
            case ($urandom_range(3))
               0:       m.mtime = $urandom_range(9);
               1:       m.mtime = $urandom_range(99999);
               2:       m.mtime = $urandom();
               default: m.mtime = 32'hFFFF_FFFF - $urandom_range(3);
            endcase
         end
         push_message(m);
         phase_items += m.len + 1;
      end
      drain_filter();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            fold_and_lookup(req_tuser, req_tdata[7:0], req_tdata[9:8], req_tdata[41:10]);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_item = pending_reqs.pop_front();
               req_tuser <= drv_item.cmd;
               req_tdata <= {6'd0, drv_item.mtime, drv_item.mtype, drv_item.sbyte};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_keys.size() == 0) begin
               $error("unexpected result transfer: key_hash %h is_replay %b", rsp_tdata,
                      rsp_tuser);
               fail_count++;
            end else begin
               exp_key = expected_keys.pop_front();
               if (rsp_tdata !== exp_key.hash) begin
                  $error("key_hash mismatch: expected %h actual %h", exp_key.hash, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== exp_key.replay) begin
                  $error("is_replay mismatch: expected %b actual %b", exp_key.replay,
                         rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      message_type m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_sign_cfg(1'b0);
      @(negedge clock);
      // empty sender, then the same key again
      m.len = 0;
      foreach (m.b[i]) m.b[i] = '0;
      m.mtype = MSG_SOS;
      m.mtime = 32'd0;
      push_message(m);
      push_message(m);
      m.len = 4;
      m.b[0] = 8'hFF;
      m.b[1] = 8'h80;
      m.b[2] = 8'h00;
      m.b[3] = 8'h7F;
      m.mtype = MSG_CHECKIN;
      m.mtime = 32'hFFFF_FFFF;
      push_message(m);
      // type code three hashes like a trail message
      m.len = 0;
      m.mtype = MSG_TYPE3;
      m.mtime = 32'd9;
      push_message(m);
      m.mtype = MSG_TRAIL;
      push_message(m);
      // zero hash hits an unwritten slot
      push_message(build_zero_key(MSG_CHECKIN, 32'd12345));
      drain_filter();

      run_phase(25, 48, 1'b1, PHASE_ITEMS);
      run_phase(48, 25, 1'b0, PHASE_ITEMS);
      run_phase(0, 0, 1'b1, PHASE_ITEMS);

      $display("%0d transfers in, %0d keys checked, %0d of them replays", accepted_count,
               results_seen, replay_count);
      $display("sign extension off and on, both rings, zero-hash and near-miss keys");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ replay_hash_filter.f @@
hw/rtl/rhf_pkg.sv
hw/rtl/rhf_decimal.sv
hw/rtl/rhf_datapath.sv
hw/rtl/rhf_controller.sv
hw/rtl/replay_hash_filter.sv
verif/tb.sv
